[rtl/core/mdh_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the message duplicate filter
// no dependencies

package mdh_pkg;

    localparam int KEY_W             = 96;
    localparam int OCC_W             = 8;
    localparam int HISTORY_DEPTH_DEF = 128;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    typedef struct packed {
        logic shift_en;
        logic clear_hit;
    } mdh_ctl_t;

endpackage

[rtl/core/message_dedup_history.sv]
`timescale 1ns / 1ps
// message duplicate filter: a row of key cells, newest key in cell 0,
// with the control sequencer and the result register; uses mdh_pkg, mdh_cell
//
// input channel s_*: s_tuser carries the operation (lookup, insert, clear),
// s_tdata the key. result channel m_*: one transaction per input transaction,
// carrying the duplicate flag and the occupancy after the operation.
// insert shifts the key into cell 0 and every stored key one cell along;
// the oldest key falls off the end once the row is full.
// lookup: the hit flag ripples through the row one cell per cycle while
// the sequencer steps through its scan state; the result is loaded from the
// row's end once the result register is free, with no new input taken before.
// insert, clear and the unused code: result registered at acceptance,
// a new transaction can follow in the next cycle.
// the result register holds while m_tready is low; a new input transaction
// is taken only when that register is free or being emptied.
// reset empties the history (occupancy 0) and drops any pending result;
// stored keys are not cleared and are never seen before being written.

module message_dedup_history import mdh_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [KEY_W-1:0] s_tdata,   // sender_hash, timestamp, message_id
    input  logic [1:0]       s_tuser,   // func
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata    // duplicate, occupancy, zero pad
);

    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int SCW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [CW-1:0]  DEPTH_C   = CW'(HISTORY_DEPTH);
    localparam logic [SCW-1:0] SCAN_LAST = SCW'(HISTORY_DEPTH - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t           state_reg, state_next;
    logic [SCW-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [KEY_W-1:0] probe_reg, probe_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             dup_reg, dup_next;
    logic [OCC_W-1:0] occ_reg, occ_next;

    logic                s_acc;
    logic                out_free;
    logic [CW-1:0]       count_inc;
    mdh_ctl_t            ctl;
    logic [KEY_W-1:0]    cell_key [HISTORY_DEPTH];
    logic [HISTORY_DEPTH:0] hit_chain;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign s_acc     = s_tvalid && s_tready;
    assign count_inc = (count_reg == DEPTH_C) ? count_reg : count_reg + CW'(1);

    assign ctl.shift_en  = s_acc && (s_tuser == FUNC_INSERT);
    assign ctl.clear_hit = s_acc && (s_tuser == FUNC_LOOKUP);

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
        logic [KEY_W-1:0] left_key;
        if (i == 0) begin : g_head
            assign left_key = s_tdata;
        end else begin : g_body
            assign left_key = cell_key[i-1];
        end
        mdh_cell #(
            .CNT_W    (CW),
            .CELL_IDX (i)
        ) u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .key_in  (left_key),
            .probe   (probe_reg),
            .count   (count_reg),
            .hit_in  (hit_chain[i]),
            .key_out (cell_key[i]),
            .hit_out (hit_chain[i+1])
        );
    end

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        count_next    = count_reg;
        probe_next    = probe_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        dup_next      = dup_reg;
        occ_next      = occ_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        FUNC_LOOKUP: begin
                            state_next    = ST_SCAN;
                            scan_cnt_next = '0;
                            probe_next    = s_tdata;
                        end
                        FUNC_INSERT: begin
                            count_next    = count_inc;
                            m_tvalid_next = 1'b1;
                            dup_next      = 1'b0;
                            occ_next      = OCC_W'(count_inc);
                        end
                        FUNC_CLEAR: begin
                            count_next    = '0;
                            m_tvalid_next = 1'b1;
                            dup_next      = 1'b0;
                            occ_next      = '0;
                        end
                        default: begin
                            m_tvalid_next = 1'b1;
                            dup_next      = 1'b0;
                            occ_next      = OCC_W'(count_reg);
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + SCW'(1);
                if (scan_cnt_reg == SCAN_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    dup_next      = hit_chain[HISTORY_DEPTH];
                    occ_next      = OCC_W'(count_reg);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        probe_reg <= probe_next;
        dup_reg   <= dup_next;
        occ_reg   <= occ_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, occ_reg, dup_reg};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("history count above depth");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_tuser == FUNC_INSERT) && (count_reg != DEPTH_C))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not advance count");

    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_tuser == FUNC_CLEAR))
        |=> (count_reg == '0) && m_tvalid && (m_tdata[8:1] == '0))
        else $error("clear did not empty history");

    a_scan_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> $stable(count_reg) && $stable(probe_reg))
        else $error("history changed during lookup scan");
`endif

endmodule

[rtl/core/mdh_cell.sv]
`timescale 1ns / 1ps
// one history cell: stores a key, shifts it right on insert,
// compares it to the probe and ripples the hit flag; uses mdh_pkg

module mdh_cell import mdh_pkg::*; #(
    parameter int CNT_W    = 8,
    parameter int CELL_IDX = 0
) (
    input  logic             aclk,
    input  mdh_ctl_t         ctl,
    input  logic [KEY_W-1:0] key_in,
    input  logic [KEY_W-1:0] probe,
    input  logic [CNT_W-1:0] count,
    input  logic             hit_in,
    output logic [KEY_W-1:0] key_out,
    output logic             hit_out
);

    logic [KEY_W-1:0] key_reg;
    logic             hit_reg;
    logic             match;

    assign match   = (key_reg == probe) && (count > CNT_W'(CELL_IDX));
    assign key_out = key_reg;
    assign hit_out = hit_reg;

    always_ff @(posedge aclk) begin
        if (ctl.shift_en) begin
            key_reg <= key_in;
        end
        if (ctl.clear_hit) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_in | match;
        end
    end

endmodule
